// File: rtl/dnsle_pkg.sv
// Package for the DNS name label encoder.
// Constants, codes and controller/datapath bundles; no dependencies.
package dnsle_pkg;

   localparam int MAX_LABEL_DEF = 63;
   localparam int STORE_DEPTH   = 63;
   localparam int LEN_W         = 6;
   localparam int POS_W         = 7;

   localparam logic [7:0] DOT_CHAR  = 8'h2E;
   localparam logic [7:0] TERM_CHAR = 8'h00;
   localparam logic [7:0] ROOT_BYTE = 8'h00;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LONG  = 2'd1,
      STATUS_EMPTY     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      COUNT_NONE = 2'd0,
      COUNT_ONE  = 2'd1,
      COUNT_TWO  = 2'd2
   } count_type;

   // controller -> datapath
   typedef struct packed {
      logic take;    // request accepted this cycle
      logic fetch;   // read label bytes for the next result
      logic emit;    // load the next result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;     // output register can take a result this cycle
      logic starts_emit;  // current request begins a label emission
      logic last_result;  // pending result closes the emission
   } stat_type;

endpackage

// File: rtl/dnsle_if.sv
// Channel interfaces for the DNS name label encoder.
// Depends on nothing; request carries one character, response one result.
interface dnsle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface dnsle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic [1:0] byte_count;
   logic       run_end;
   logic       name_done;
   logic [1:0] status;

   modport source (output valid, output first_byte, output second_byte,
                   output byte_count, output run_end, output name_done,
                   output status, input ready);
   modport sink   (input valid, input first_byte, input second_byte,
                   input byte_count, input run_end, input name_done,
                   input status, output ready);
endinterface

// File: rtl/dnsle_ctrl.sv
// Controller of the DNS name label encoder: sequences request intake,
// label reads and result loads. Depends on dnsle_pkg.
module dnsle_ctrl import dnsle_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free && !reset;
            cmd.take  = req_valid && req_ready;
            if (cmd.take && stat.starts_emit) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register frees up
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.last_result ? ST_IDLE : ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/dnsle_dp.sv
// Datapath of the DNS name label encoder: label store, label state,
// result packing and output register. Depends on dnsle_pkg.
module dnsle_dp import dnsle_pkg::*; #(
   parameter int MAX_LABEL = MAX_LABEL_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [7:0] req_char_in,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic [7:0] rsp_first_byte,
   output logic [7:0] rsp_second_byte,
   output logic [1:0] rsp_byte_count,
   output logic       rsp_run_end,
   output logic       rsp_name_done,
   output logic [1:0] rsp_status
);

   localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_LABEL);
   localparam logic [POS_W-1:0] DEPTH_P  = POS_W'(STORE_DEPTH);

   logic [7:0]       store_mem [STORE_DEPTH];
   logic [7:0]       rd0_ff, rd1_ff;

   logic [LEN_W-1:0] len_ff, len_in;
   logic             started_ff, started_in;
   logic             discard_ff, discard_in;
   logic             final_ff, final_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       second_ff, second_in;
   logic [1:0]       count_ff, count_in;
   logic             end_ff, end_in;
   logic             done_ff, done_in;
   logic [1:0]       status_ff, status_in;

   logic             is_term, is_dot, too_long, store_wr;
   logic [POS_W-1:0] n_bytes, pos_m1, pos_p1, pos_p2;
   logic [LEN_W-1:0] addr0, addr1;
   logic             two, last;

   assign is_term  = (req_char_in == TERM_CHAR);
   assign is_dot   = (req_char_in == DOT_CHAR);
   assign too_long = (len_ff >= MAX_LEN);
   assign store_wr = cmd.take && !discard_ff && !is_term && !is_dot && !too_long;

   // emission geometry: length byte, label bytes, root byte when final
   assign n_bytes = {1'b0, len_ff} + POS_W'(1) + POS_W'(final_ff);
   assign pos_m1  = pos_ff - POS_W'(1);
   assign pos_p1  = pos_ff + POS_W'(1);
   assign pos_p2  = pos_ff + POS_W'(2);
   assign two     = (pos_p1 < n_bytes);
   assign last    = (pos_p2 >= n_bytes);
   assign addr0   = (pos_m1 >= DEPTH_P) ? '0 : pos_m1[LEN_W-1:0];
   assign addr1   = (pos_ff >= DEPTH_P) ? '0 : pos_ff[LEN_W-1:0];

   assign stat.out_free    = !out_valid_ff || rsp_ready;
   assign stat.starts_emit = !discard_ff && (is_term ? started_ff : is_dot);
   assign stat.last_result = last;

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[len_ff] <= req_char_in;
      end
      if (cmd.fetch) begin
         rd0_ff <= store_mem[addr0];
         rd1_ff <= store_mem[addr1];
      end
   end

   always_comb begin
      len_in       = len_ff;
      started_in   = started_ff;
      discard_in   = discard_ff;
      final_in     = final_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      first_in     = first_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      end_in       = end_ff;
      done_in      = done_ff;
      status_in    = status_ff;

      if (cmd.take) begin
         if (discard_ff) begin
            // drop everything up to the terminator
            if (is_term) begin
               discard_in = 1'b0;
               len_in     = '0;
               started_in = 1'b0;
            end
         end else if (is_term && !started_ff) begin
            out_valid_in = 1'b1;
            first_in     = '0;
            second_in    = '0;
            count_in     = COUNT_NONE;
            end_in       = 1'b1;
            done_in      = 1'b1;
            status_in    = STATUS_EMPTY;
            len_in       = '0;
         end else if (is_term || is_dot) begin
            final_in   = is_term;
            pos_in     = '0;
            started_in = 1'b1;
         end else if (too_long) begin
            out_valid_in = 1'b1;
            first_in     = '0;
            second_in    = '0;
            count_in     = COUNT_NONE;
            end_in       = 1'b1;
            done_in      = 1'b1;
            status_in    = STATUS_TOO_LONG;
            len_in       = '0;
            discard_in   = 1'b1;
            started_in   = 1'b1;
         end else begin
            len_in     = len_ff + LEN_W'(1);
            started_in = 1'b1;
         end
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         first_in     = (pos_ff == '0) ? {{(8-LEN_W){1'b0}}, len_ff} :
                        (pos_ff <= {1'b0, len_ff}) ? rd0_ff : ROOT_BYTE;
         second_in    = !two ? 8'h00 :
                        (pos_p1 <= {1'b0, len_ff}) ? rd1_ff : ROOT_BYTE;
         count_in     = two ? COUNT_TWO : COUNT_ONE;
         end_in       = last;
         done_in      = last && final_ff;
         status_in    = STATUS_OK;
         pos_in       = pos_p2;
         if (last) begin
            len_in = '0;
            if (final_ff) begin
               started_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         started_ff   <= 1'b0;
         discard_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         started_ff   <= started_in;
         discard_ff   <= discard_in;
         out_valid_ff <= out_valid_in;
      end
      final_ff  <= final_in;
      pos_ff    <= pos_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      count_ff  <= count_in;
      end_ff    <= end_in;
      done_ff   <= done_in;
      status_ff <= status_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_first_byte  = first_ff;
   assign rsp_second_byte = second_ff;
   assign rsp_byte_count  = count_ff;
   assign rsp_run_end     = end_ff;
   assign rsp_name_done   = done_ff;
   assign rsp_status      = status_ff;

endmodule

// File: rtl/dns_name_label_encoder.sv
// Channel   Dir  Payload                                           Role
// req_ch    in   char_in[7:0]                                      one name character
// rsp_ch    out  first_byte, second_byte, byte_count, run_end,     packed wire bytes
//                name_done, status
//
// A character that gives no result, or a single error result, is handled in its accept cycle.
// A dot or terminator is accepted, then emits ceil((len + 1 + final) / 2) results, each by
// a label store read, then an output register load; the load waits while the output
// register cannot take a result. Requests stall while an emission runs or while any result
// waits in the output register.
// Synchronous reset clears control state; the label store is not cleared.
//
// Top level of the DNS name label encoder; depends on dnsle_pkg, dnsle_if,
// dnsle_ctrl and dnsle_dp.
module dns_name_label_encoder import dnsle_pkg::*; #(
   parameter int MAX_LABEL = MAX_LABEL_DEF
) (
   input logic        clock,
   input logic        reset,
   dnsle_req_if.sink   req_ch,
   dnsle_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   dnsle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dnsle_dp #(
      .MAX_LABEL (MAX_LABEL)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_char_in     (req_ch.char_in),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_first_byte  (rsp_ch.first_byte),
      .rsp_second_byte (rsp_ch.second_byte),
      .rsp_byte_count  (rsp_ch.byte_count),
      .rsp_run_end     (rsp_ch.run_end),
      .rsp_name_done   (rsp_ch.name_done),
      .rsp_status      (rsp_ch.status)
   );

endmodule

// File: test/tb.sv
// Self-checking testbench for dns_name_label_encoder: streams dotted names and checks every
// packed wire-format result against an in-bench scoreboard.
// Depends on rtl/dnsle_pkg.sv, rtl/dnsle_if.sv and the encoder RTL.
`timescale 1ns / 1ps

module tb import dnsle_pkg::*; ();

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_CYCLES  = 300;

   typedef struct {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] byte_count;
      logic       run_end;
      logic       name_done;
      logic [1:0] status;
   } wire_result_type;

   class label_scoreboard;
      logic [7:0]      label_chars [STORE_DEPTH];
      int unsigned     label_count;
      bit              started;
      bit              discarding;
      wire_result_type pending [$];
      int              errors;
      int              results_checked;
      int              names_finished;
      int              too_long_seen;
      int              empty_seen;

      function void push_error(logic [1:0] code);
         wire_result_type r;
         r.first_byte  = 8'h00;
         r.second_byte = 8'h00;
         r.byte_count  = COUNT_NONE;
         r.run_end     = 1'b1;
         r.name_done   = 1'b1;
         r.status      = code;
         pending.push_back(r);
      endfunction

      // Length byte, label bytes, root byte when the name closes; two bytes per result.
      function void emit_label(bit closes_name);
         logic [7:0]      wire_bytes [$];
         int unsigned     i;
         wire_result_type r;
         wire_bytes.push_back(8'(label_count));
         for (i = 0; i < label_count; i++) wire_bytes.push_back(label_chars[i]);
         if (closes_name) wire_bytes.push_back(ROOT_BYTE);
         for (i = 0; i < wire_bytes.size(); i += 2) begin
            r.first_byte = wire_bytes[i];
            if (i + 1 < wire_bytes.size()) begin
               r.second_byte = wire_bytes[i + 1];
               r.byte_count  = COUNT_TWO;
            end else begin
               r.second_byte = 8'h00;
               r.byte_count  = COUNT_ONE;
            end
            r.run_end   = (i + 2 >= wire_bytes.size());
            r.name_done = r.run_end && closes_name;
            r.status    = STATUS_OK;
            pending.push_back(r);
         end
      endfunction

      function void note_char(logic [7:0] c);
         if (discarding) begin
            if (c == TERM_CHAR) begin
               discarding  = 1'b0;
               label_count = 0;
               started     = 1'b0;
            end
            return;
         end
         if (c == TERM_CHAR) begin
            if (!started) push_error(STATUS_EMPTY);
            else emit_label(1'b1);
            label_count = 0;
            started     = 1'b0;
            return;
         end
         started = 1'b1;
         if (c == DOT_CHAR) begin
            emit_label(1'b0);
            label_count = 0;
            return;
         end
         if (label_count >= MAX_LABEL_DEF) begin
            push_error(STATUS_TOO_LONG);
            label_count = 0;
            discarding  = 1'b1;
            return;
         end
         label_chars[label_count] = c;
         label_count++;
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(wire_result_type got);
         wire_result_type want;
         if (pending.size() == 0) begin
            $error("result with none pending: first_byte %0h byte_count %0d status %0d",
                   got.first_byte, got.byte_count, got.status);
            errors++;
            return;
         end
         want = pending.pop_front();
         results_checked++;
         if (want.name_done && want.status == STATUS_OK) names_finished++;
         if (want.status == STATUS_TOO_LONG) too_long_seen++;
         if (want.status == STATUS_EMPTY) empty_seen++;
         compare_field("first_byte", want.first_byte, got.first_byte);
         compare_field("second_byte", want.second_byte, got.second_byte);
         compare_field("byte_count", 8'(want.byte_count), 8'(got.byte_count));
         compare_field("run_end", 8'(want.run_end), 8'(got.run_end));
         compare_field("name_done", 8'(want.name_done), 8'(got.name_done));
         compare_field("status", 8'(want.status), 8'(got.status));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   dnsle_req_if req_ch ();
   dnsle_rsp_if rsp_ch ();

   dns_name_label_encoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   label_scoreboard sb;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int stall_request = 0;
   int chars_sent    = 0;
   int cycle_count   = 0;

   logic [7:0] directed_chars [22] = '{
      TERM_CHAR,
      DOT_CHAR, TERM_CHAR,
      8'hFF, 8'h01, DOT_CHAR, DOT_CHAR, 8'h80, 8'h7F, DOT_CHAR, TERM_CHAR,
      DOT_CHAR, 8'h41, TERM_CHAR,
      8'h61, 8'h62, TERM_CHAR,
      8'h41, 8'h42, 8'h43, TERM_CHAR,
      TERM_CHAR
   };

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: random back-pressure, or a long hold-off when one is requested.
   initial begin
      int hold;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request != 0) begin
            hold          = stall_request;
            stall_request = 0;
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Sample at the falling edge; the response is taken at the next rising edge.
   always @(negedge clock) begin
      wire_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.first_byte  = rsp_ch.first_byte;
         got.second_byte = rsp_ch.second_byte;
         got.byte_count  = rsp_ch.byte_count;
         got.run_end     = rsp_ch.run_end;
         got.name_done   = rsp_ch.name_done;
         got.status      = rsp_ch.status;
         sb.check_result(got);
      end
   end

   task automatic send_char(logic [7:0] c);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= c;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      sb.note_char(c);
      chars_sent++;
   endtask

   function automatic logic [7:0] label_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == DOT_CHAR);
      return c;
   endfunction

   task automatic send_label(int len);
      for (int i = 0; i < len; i++) send_char(label_char());
   endtask

   // Well-formed name: a few labels, some empty, sometimes a trailing dot.
   task automatic send_random_name();
      int labels;
      int pick;
      labels = $urandom_range(1, 4);
      for (int n = 0; n < labels; n++) begin
         pick = $urandom_range(99);
         if (pick < 10) send_label(0);
         else if (pick < 90) send_label($urandom_range(1, 8));
         else send_label($urandom_range(9, 24));
         if (n < labels - 1) send_char(DOT_CHAR);
      end
      if ($urandom_range(99) < 15) send_char(DOT_CHAR);
      send_char(TERM_CHAR);
   endtask

   task automatic send_noise();
      int len;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 30) send_char(DOT_CHAR);
         else send_char(8'($urandom_range(1, 255)));
      end
      send_char(TERM_CHAR);
   endtask

   task automatic run_random(int target);
      int pick;
      while (chars_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 75) send_random_name();
         else if (pick < 92) send_noise();
         else send_char(TERM_CHAR);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      sb = new();
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.char_in <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      rsp_idle_pct  = 56;
      foreach (directed_chars[i]) send_char(directed_chars[i]);
      run_random(120);
      req_ch.valid <= 1'b0;
      wait_drained();

      send_idle_pct = 56;
      rsp_idle_pct  = 11;
      run_random(240);
      req_ch.valid <= 1'b0;
      wait_drained();

      // Hold the receiver while a maximum-length label backs up the encoder.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      stall_request = STALL_CYCLES;
      send_char(8'h61);
      send_char(DOT_CHAR);
      send_label(MAX_LABEL_DEF);
      send_char(TERM_CHAR);
      // Overlong second label: drop the rest, dots included, up to the terminator.
      send_char(8'h71);
      send_char(DOT_CHAR);
      send_label(MAX_LABEL_DEF + 1);
      send_char(DOT_CHAR);
      send_char(8'h7A);
      send_char(8'h7A);
      send_char(TERM_CHAR);
      send_char(TERM_CHAR);
      run_random(460);
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: sent %0d characters, checked %0d results, %0d names completed",
               chars_sent, sb.results_checked, sb.names_finished);
      $display("tb: %0d overlong-label aborts and %0d empty names seen",
               sb.too_long_seen, sb.empty_seen);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
